### sv/scd_pkg.sv
// Shared constants for the degree sine/cosine pipeline: default parameters,
// fixed-point working widths and the degree-to-radian scale.
// No dependencies.
package scd_pkg;

  // Default configuration
  localparam int SERIES_TERMS_DEF     = 21;
  localparam int ANGLE_FRAC_BITS_DEF  = 16;
  localparam int RESULT_FRAC_BITS_DEF = 30;

  // Port widths
  localparam int ANGLE_W  = 32;
  localparam int RESULT_W = 32;

  // Working format is unsigned Q54
  localparam int WORK_BITS   = 54;
  localparam int THETA_W     = 57;  // theta < 2*pi
  localparam int X2_W        = 60;  // theta^2 < 40
  localparam int TERM_W      = 61;  // largest series term < 128
  localparam int NUM_W       = 61;  // rounded dividend x2 + d/2
  localparam int RECIP_SHIFT = 61;  // reciprocal scale for constant division
  localparam int QUOT_W      = 60;
  localparam int ACC_W       = 64;

  localparam int DEG_TURN = 360;

  // pi * 2^62, and pi/180 * 2^64 rounded
  localparam logic [63:0] PI_Q62      = 64'hC90FDAA22168C235;
  localparam logic [63:0] DEG2RAD_Q64 = (PI_Q62 + 64'd22) / 64'd45;

  localparam logic [TERM_W-1:0] ONE_WORK = TERM_W'(1) << WORK_BITS;

  // Series lanes
  localparam int CH_SIN = 0;
  localparam int CH_COS = 1;

endpackage

### sv/scd_mul.sv
// Two-stage unsigned multiplier with right shift and optional round half up.
// Built from four 32x32 partial products; no package dependencies.
module scd_mul #(
  parameter int A_W   = 64,
  parameter int B_W   = 64,
  parameter int OUT_W = 64,
  parameter int SHIFT = 1,
  parameter bit ROUND = 1'b1
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  output logic [OUT_W-1:0] p
);

  localparam logic [127:0] RND = ROUND ? (128'd1 << (SHIFT - 1)) : 128'd0;

  logic [63:0]      a_x;
  logic [63:0]      b_x;
  logic [63:0]      ll_r;
  logic [63:0]      lh_r;
  logic [63:0]      hl_r;
  logic [63:0]      hh_r;
  logic [127:0]     sum;
  logic [OUT_W-1:0] p_r;

  assign a_x = 64'(a);
  assign b_x = 64'(b);

  // Form partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      ll_r <= 64'(a_x[31:0]) * 64'(b_x[31:0]);
      lh_r <= 64'(a_x[31:0]) * 64'(b_x[63:32]);
      hl_r <= 64'(a_x[63:32]) * 64'(b_x[31:0]);
      hh_r <= 64'(a_x[63:32]) * 64'(b_x[63:32]);
    end
  end

  // Sum, round and shift
  assign sum = {hh_r, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + RND;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= sum[SHIFT +: OUT_W];
    end
  end

  assign p = p_r;

endmodule

### sv/sine_cosine_degrees.sv
// Sine and cosine of an angle in degrees, fully pipelined Taylor series.
// Depends on scd_pkg and scd_mul.
//
// Usage:
//   Input channel (in_valid / in_stall / in_angle_deg): one angle per beat,
//   signed, ANGLE_FRAC_BITS fractional bits. Any angle is reduced by floor
//   modulo 360 degrees, so negative angles wrap like positive ones.
//   Output channel (out_valid / out_stall / out_sine_value / out_cosine_value):
//   one beat per angle, in order, RESULT_FRAC_BITS fractional bits, clamped
//   to plus or minus one.
//   Throughput: one angle per cycle while the output is not stalled. Each
//   series term comes from a two-stage multiply unit, so every term
//   lengthens the pipeline but adds no stall.
//   A stalled output holds its beat and freezes the whole pipeline;
//   in_stall rises only while out_valid is high and out_stall is high.
//   Reset clears every valid bit; no clearing pass is needed and the block
//   accepts an angle in the first cycle after reset.
module sine_cosine_degrees
  import scd_pkg::*;
#(
  parameter int SERIES_TERMS     = SERIES_TERMS_DEF,
  parameter int ANGLE_FRAC_BITS  = ANGLE_FRAC_BITS_DEF,
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [ANGLE_W-1:0]  in_angle_deg,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [RESULT_W-1:0] out_sine_value,
  output logic signed [RESULT_W-1:0] out_cosine_value
);

  localparam int          NRED        = 24 - ANGLE_FRAC_BITS;
  localparam logic [63:0] FULL_TURN   = 64'(DEG_TURN) << ANGLE_FRAC_BITS;
  localparam logic [63:0] OFFSET_MOD  = (64'd1 << 31) % FULL_TURN;
  localparam int          REM_W       = ANGLE_FRAC_BITS + 9;
  localparam int          REM_XW      = REM_W + 1;
  localparam int          THETA_SHIFT = 64 - WORK_BITS + ANGLE_FRAC_BITS;
  localparam int          LAT         = NRED + 2 * SERIES_TERMS + 12;
  localparam int          X2_LEN      = 2 * SERIES_TERMS - 4;
  localparam int          TH_LEN      = 6;
  localparam int          RND_SHIFT   = WORK_BITS - RESULT_FRAC_BITS;
  localparam int          MAG_W       = RESULT_FRAC_BITS + 1;
  localparam logic [MAG_W-1:0]  MAG_LIM  = MAG_W'(1) << RESULT_FRAC_BITS;
  localparam logic [REM_XW-1:0] OFS_X    = REM_XW'(OFFSET_MOD);
  localparam logic [REM_XW-1:0] TURN_X   = REM_XW'(FULL_TURN);
  localparam logic [ACC_W:0]    RND_HALF = (ACC_W + 1)'(1) << (RND_SHIFT - 1);

  logic                 adv;
  logic [LAT-1:0]       vld_r;
  logic [ANGLE_W-1:0]   red_r [NRED+1];
  logic [REM_XW-1:0]    red_x;
  logic [REM_XW-1:0]    rem_nxt;
  logic [REM_W-1:0]     rem_r;
  logic [THETA_W-1:0]   theta_w;
  logic [X2_W-1:0]      x2_w;
  logic [THETA_W-1:0]   th_d_r [TH_LEN];
  logic [X2_W-1:0]      x2_d_r [1:X2_LEN];
  logic [TERM_W-1:0]    term_w [2][SERIES_TERMS];
  logic [ACC_W-1:0]     pos_w  [2][SERIES_TERMS];
  logic [ACC_W-1:0]     neg_w  [2][SERIES_TERMS];
  logic [RESULT_W-1:0]  res_w  [2];

  // Advance the whole pipeline unless the output beat is blocked
  assign out_valid = vld_r[LAT-1];
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Bias the angle to unsigned, then reduce by restoring subtraction
  always_ff @(posedge clk) begin
    if (adv) begin
      red_r[0] <= {~in_angle_deg[ANGLE_W-1], in_angle_deg[ANGLE_W-2:0]};
    end
  end

  for (genvar i = 1; i <= NRED; i++) begin : g_red
    localparam logic [ANGLE_W-1:0] SUB = ANGLE_W'(FULL_TURN << (NRED - i));
    always_ff @(posedge clk) begin
      if (adv) begin
        red_r[i] <= (red_r[i-1] >= SUB) ? red_r[i-1] - SUB : red_r[i-1];
      end
    end
  end

  // Remove the bias modulo one turn
  assign red_x   = REM_XW'(red_r[NRED]);
  assign rem_nxt = (red_x >= OFS_X) ? red_x - OFS_X : red_x + (TURN_X - OFS_X);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt[REM_W-1:0];
    end
  end

  // Convert to radians, then square
  scd_mul #(
    .A_W(REM_W), .B_W(64), .OUT_W(THETA_W), .SHIFT(THETA_SHIFT), .ROUND(1'b1)
  ) u_theta (
    .clk(clk), .adv(adv), .a(rem_r), .b(DEG2RAD_Q64), .p(theta_w)
  );

  scd_mul #(
    .A_W(THETA_W), .B_W(THETA_W), .OUT_W(X2_W), .SHIFT(WORK_BITS), .ROUND(1'b1)
  ) u_x2 (
    .clk(clk), .adv(adv), .a(theta_w), .b(theta_w), .p(x2_w)
  );

  // Delay theta and theta^2 to line up with the series chain
  always_ff @(posedge clk) begin
    if (adv) begin
      th_d_r[0] <= theta_w;
      for (int j = 1; j < TH_LEN; j++) begin
        th_d_r[j] <= th_d_r[j-1];
      end
      x2_d_r[1] <= x2_w;
      for (int j = 2; j <= X2_LEN; j++) begin
        x2_d_r[j] <= x2_d_r[j-1];
      end
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_ch
    // Seed the series with its first term
    if (c == CH_SIN) begin : g_seed_sin
      assign term_w[c][0] = TERM_W'(th_d_r[TH_LEN-1]);
    end else begin : g_seed_cos
      assign term_w[c][0] = ONE_WORK;
    end
    assign pos_w[c][0] = '0;
    assign neg_w[c][0] = '0;

    for (genvar n = 1; n < SERIES_TERMS; n++) begin : g_term
      localparam int K1 = (c == CH_SIN) ? 2 * n : 2 * n - 1;
      localparam int DIV = K1 * (K1 + 1);
      localparam int RB = $clog2(DIV) + 2;
      localparam logic [NUM_W-1:0] HALF_D = NUM_W'(DIV / 2);
      localparam logic [63:0] RECIP = (64'd1 << RECIP_SHIFT) / 64'(DIV);
      localparam bit PREV_EVEN = ((n - 1) % 2) == 0;

      logic [X2_W-1:0]   x2_tap;
      logic [NUM_W-1:0]  num_r;
      logic [RB-1:0]     nlo1_r;
      logic [RB-1:0]     nlo2_r;
      logic [QUOT_W-1:0] q0_w;
      logic [QUOT_W-1:0] q_r;
      logic [RB-1:0]     rem_lo;
      logic [ACC_W-1:0]  pm_r;
      logic [ACC_W-1:0]  nm_r;
      logic [ACC_W-1:0]  po_r;
      logic [ACC_W-1:0]  no_r;

      if (n == 1) begin : g_tap0
        assign x2_tap = x2_w;
      end else begin : g_tapn
        assign x2_tap = x2_d_r[2*n-2];
      end

      // Divide theta^2 by the term's constant, rounded: reciprocal then fix-up
      scd_mul #(
        .A_W(NUM_W), .B_W(64), .OUT_W(QUOT_W), .SHIFT(RECIP_SHIFT), .ROUND(1'b0)
      ) u_div (
        .clk(clk), .adv(adv), .a(num_r), .b(RECIP), .p(q0_w)
      );

      assign rem_lo = nlo2_r - RB'(q0_w[RB-1:0] * RB'(DIV));

      always_ff @(posedge clk) begin
        if (adv) begin
          num_r  <= NUM_W'(x2_tap) + HALF_D;
          nlo1_r <= num_r[RB-1:0];
          nlo2_r <= nlo1_r;
          q_r    <= (rem_lo >= RB'(DIV)) ? q0_w + QUOT_W'(1) : q0_w;
        end
      end

      // Next term = previous term times quotient
      scd_mul #(
        .A_W(TERM_W), .B_W(QUOT_W), .OUT_W(TERM_W), .SHIFT(WORK_BITS), .ROUND(1'b1)
      ) u_term (
        .clk(clk), .adv(adv), .a(term_w[c][n-1]), .b(q_r), .p(term_w[c][n])
      );

      // Fold the previous term into its sum while the multiply runs
      always_ff @(posedge clk) begin
        if (adv) begin
          if (PREV_EVEN) begin
            pm_r <= pos_w[c][n-1] + ACC_W'(term_w[c][n-1]);
            nm_r <= neg_w[c][n-1];
          end else begin
            pm_r <= pos_w[c][n-1];
            nm_r <= neg_w[c][n-1] + ACC_W'(term_w[c][n-1]);
          end
          po_r <= pm_r;
          no_r <= nm_r;
        end
      end

      assign pos_w[c][n] = po_r;
      assign neg_w[c][n] = no_r;
    end

    // Close the sums, take the difference, round, clamp and sign
    localparam bit LAST_EVEN = ((SERIES_TERMS - 1) % 2) == 0;

    logic [ACC_W-1:0]    pf_r;
    logic [ACC_W-1:0]    nf_r;
    logic [ACC_W-1:0]    dif_r;
    logic                neg1_r;
    logic                neg2_r;
    logic [ACC_W:0]      rsum;
    logic [ACC_W:0]      rd;
    logic [MAG_W-1:0]    mag_r;
    logic [RESULT_W-1:0] res_r;

    assign rsum = {1'b0, dif_r} + RND_HALF;
    assign rd   = rsum >> RND_SHIFT;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (LAST_EVEN) begin
          pf_r <= pos_w[c][SERIES_TERMS-1] + ACC_W'(term_w[c][SERIES_TERMS-1]);
          nf_r <= neg_w[c][SERIES_TERMS-1];
        end else begin
          pf_r <= pos_w[c][SERIES_TERMS-1];
          nf_r <= neg_w[c][SERIES_TERMS-1] + ACC_W'(term_w[c][SERIES_TERMS-1]);
        end
        neg1_r <= nf_r > pf_r;
        dif_r  <= (nf_r > pf_r) ? nf_r - pf_r : pf_r - nf_r;
        neg2_r <= neg1_r;
        mag_r  <= (rd > (ACC_W + 1)'(MAG_LIM)) ? MAG_LIM : MAG_W'(rd);
        res_r  <= neg2_r ? RESULT_W'(0) - RESULT_W'(mag_r) : RESULT_W'(mag_r);
      end
    end

    assign res_w[c] = res_r;
  end

  assign out_sine_value   = res_w[CH_SIN];
  assign out_cosine_value = res_w[CH_COS];

endmodule

### sv/scd_checker.sv
// Port-level checks for sine_cosine_degrees, bound to the top level.
// Depends on scd_pkg.
module scd_checker
  import scd_pkg::*;
#(
  parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [RESULT_W-1:0] out_sine_value,
  input logic signed [RESULT_W-1:0] out_cosine_value
);

  localparam logic signed [RESULT_W-1:0] LIM_POS = RESULT_W'(1) << RESULT_FRAC_BITS;
  localparam logic signed [RESULT_W-1:0] LIM_NEG = -LIM_POS;

  // Hold a blocked output beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sine_value)
                               && $stable(out_cosine_value))
    else $error("output beat changed while stalled");

  // Stall the input only when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output");

  // Results stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sine_value <= LIM_POS && out_sine_value >= LIM_NEG
                  && out_cosine_value <= LIM_POS && out_cosine_value >= LIM_NEG)
    else $error("result outside plus or minus one");

  // Drop all beats at reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind sine_cosine_degrees scd_checker #(
  .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_scd_checker (.*);

### bench/tb_top.sv
// Testbench for sine_cosine_degrees: drives angles, predicts sine and cosine
// with a fixed-point Taylor series in the bench, and checks every beat in order.
// Depends on scd_pkg and the sine_cosine_degrees RTL.
`timescale 1ns / 100ps

module tb_top;
  import scd_pkg::*;

  localparam int N_TERMS   = SERIES_TERMS_DEF;
  localparam int A_FRAC    = ANGLE_FRAC_BITS_DEF;
  localparam int R_FRAC    = RESULT_FRAC_BITS_DEF;
  localparam int LATENCY   = 36 - A_FRAC + 2 * N_TERMS;
  localparam int STALL_MAX = 2000;

  typedef struct packed {
    logic signed [RESULT_W-1:0] sine;
    logic signed [RESULT_W-1:0] cosine;
  } trig_pair_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [ANGLE_W-1:0]  in_angle_deg = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [RESULT_W-1:0] out_sine_value;
  logic signed [RESULT_W-1:0] out_cosine_value;

  trig_pair_t pending_trig[$];
  int         error_count = 0;
  int         angles_sent = 0;
  int         beats_checked = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  always #5 clk = ~clk;

  sine_cosine_degrees u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_angle_deg     (in_angle_deg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sine_value   (out_sine_value),
    .out_cosine_value (out_cosine_value)
  );

  // round(a*b / 2^s) half up, exact 128-bit product
  function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b) + (128'(1) << (s - 1));
    return 64'(prod >> s);
  endfunction

  function automatic logic [RESULT_W-1:0] taylor_sum(logic [63:0] theta,
                                                      logic [63:0] x2, bit odd);
    logic [63:0] term, pos, neg, mag, d;
    bit          negative;
    term = odd ? theta : (64'd1 << WORK_BITS);
    pos  = term;
    neg  = 0;
    for (int n = 1; n < N_TERMS; n++) begin
      d = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
      term = mul_round(term, (x2 + d / 2) / d, WORK_BITS);
      if (n % 2) neg += term;
      else pos += term;
    end
    negative = neg > pos;
    mag = negative ? neg - pos : pos - neg;
    mag = mul_round(mag, 64'd1, WORK_BITS - R_FRAC);
    if (mag > (64'd1 << R_FRAC)) mag = 64'd1 << R_FRAC;
    return negative ? RESULT_W'(-mag) : RESULT_W'(mag);
  endfunction

  function automatic trig_pair_t predict_trig(logic signed [ANGLE_W-1:0] angle);
    longint      turn, rem;
    logic [63:0] theta, x2;
    trig_pair_t  res;
    turn = longint'(DEG_TURN) << A_FRAC;
    rem  = longint'(angle) % turn;
    if (rem < 0) rem += turn;
    theta = mul_round(64'(rem), DEG2RAD_Q64, 64 - WORK_BITS + A_FRAC);
    x2    = mul_round(theta, theta, WORK_BITS);
    res.sine   = taylor_sum(theta, x2, 1'b1);
    res.cosine = taylor_sum(theta, x2, 1'b0);
    return res;
  endfunction

  // Send one angle beat, with random idle before it; valid stays high
  // between back-to-back beats and drops only while idling
  task automatic send_angle(logic signed [ANGLE_W-1:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_angle_deg <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_trig.push_back(predict_trig(angle));
    angles_sent++;
    @(negedge clk);
  endtask

  // Randomize receiver stall each cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    trig_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_trig.size() == 0) begin
        $display("%0t: unexpected beat sin=%0d cos=%0d", $time,
                 out_sine_value, out_cosine_value);
        error_count++;
      end else begin
        want = pending_trig.pop_front();
        beats_checked++;
        if (out_sine_value !== want.sine) begin
          $display("%0t: sine expected %0d actual %0d", $time, want.sine,
                   out_sine_value);
          error_count++;
        end
        if (out_cosine_value !== want.cosine) begin
          $display("%0t: cosine expected %0d actual %0d", $time, want.cosine,
                   out_cosine_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no accepted beat on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_MAX + 4 * LATENCY) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [ANGLE_W-1:0] deg(int whole);
    return ANGLE_W'(whole <<< A_FRAC);
  endfunction

  // Extremes, quadrants, multiples of a turn and negative angles
  task automatic test_directed();
    logic signed [ANGLE_W-1:0] list[$];
    list = '{32'sh7FFFFFFF, 32'sh80000000, 0, 1, -1, deg(90), deg(180), deg(270),
             deg(360), deg(720), deg(-90), deg(-360), deg(-180), deg(45), deg(30),
             deg(359), deg(32767), deg(-32768), 32'h5555AAAA, 32'hAAAA5555,
             deg(359) + 32'hFFFF, deg(1) - 1};
    foreach (list[i]) send_angle(list[i]);
  endtask

  // Random angles: mostly within one or two turns, some full range
  task automatic test_random(int count);
    logic signed [ANGLE_W-1:0] a;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: a = $urandom;
        1: a = $signed($urandom_range(2 * 360 << A_FRAC)) - (360 <<< A_FRAC);
        2: a = deg($urandom_range(720) - 360);
        default: a = $urandom_range(360 << A_FRAC);
      endcase
      send_angle(a);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(350);
    send_idle_pct = 46; recv_stall_pct = 0;  test_random(350);
    send_idle_pct = 0;  recv_stall_pct = 46; test_random(350);
    send_idle_pct = 12; recv_stall_pct = 12; test_random(350);
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (pending_trig.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d angles, %0d result beats checked, under four idle mixes.",
             angles_sent, beats_checked);
    if (error_count == 0 && pending_trig.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

### sine_cosine_degrees.f
sv/scd_pkg.sv
sv/scd_mul.sv
sv/sine_cosine_degrees.sv
sv/scd_checker.sv
bench/tb_top.sv
